// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and character / token codes for the markup token scanner
// ----------------------------------------------------------------------------
package mts_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_SWALLOW = 3'd1,
    M_RUN     = 3'd2,
    M_HEADING = 3'd3,
    M_NUM     = 3'd4,
    M_TEXT    = 3'd5
  } mode_t;

  // characters of interest
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // token kinds
  localparam logic [5:0] K_EOF       = 6'd0;
  localparam logic [5:0] K_TEXT      = 6'd1;
  localparam logic [5:0] K_NUM       = 6'd2;
  localparam logic [5:0] K_HEAD_BASE = 6'd2;
  localparam logic [5:0] K_LBRACK    = 6'd9;
  localparam logic [5:0] K_RBRACK    = 6'd10;
  localparam logic [5:0] K_EQ        = 6'd11;
  localparam logic [5:0] K_DOT       = 6'd12;
  localparam logic [5:0] K_PLUS      = 6'd13;
  localparam logic [5:0] K_LPAREN    = 6'd14;
  localparam logic [5:0] K_RPAREN    = 6'd15;
  localparam logic [5:0] K_LT        = 6'd16;
  localparam logic [5:0] K_GT        = 6'd17;
  localparam logic [5:0] K_BANG      = 6'd18;
  localparam logic [5:0] K_STAR      = 6'd19;
  localparam logic [5:0] K_MINUS     = 6'd22;
  localparam logic [5:0] K_UNDER     = 6'd25;
  localparam logic [5:0] K_TICK      = 6'd28;
  localparam logic [5:0] K_TAB       = 6'd31;
  localparam logic [5:0] K_NEWLINE   = 6'd32;

  localparam logic [2:0] RUN_CAP     = 3'd4;
  localparam logic [2:0] HASH_CAP    = 3'd7;
  localparam logic [2:0] HEAD_LEVELS = 3'd6;

  localparam int unsigned TOKEN_BITS = 102;
  localparam int unsigned TDATA_BITS = 104;

  typedef struct packed {
    logic [31:0] line_number;
    logic [31:0] token_length;
    logic [31:0] start_offset;
    logic [5:0]  token_kind;
  } token_t;

  // results of one step: primary token then the one from a fresh byte or eof
  typedef struct packed {
    logic   a_valid;
    token_t a_tok;
    logic   b_valid;
    token_t b_tok;
  } res_pair_t;

endpackage

// File: rtl/core/mts_step.sv
// ----------------------------------------------------------------------------
// mts_step
// scanner state registers and the single-pass next-state / token logic
// ----------------------------------------------------------------------------
module mts_step #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire_i,
  input  logic                is_end_i,
  input  logic [7:0]          byte_i,
  output mts_pkg::res_pair_t  res_o
);

  localparam logic [31:0] LINE_MAX = '1;

  mts_pkg::mode_t          mode_r, mode_nxt;
  logic [7:0]              run_char_r, run_char_nxt;
  logic [2:0]              run_count_r, run_count_nxt;
  logic [5:0]              pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0]  tstart_r, tstart_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [31:0]             line_r, line_nxt;

  logic [OFFSET_BITS-1:0]  np;
  logic [31:0]             line_inc;

  // decode of a byte that starts a new token
  mts_pkg::mode_t fr_mode;
  logic           fr_put;
  logic [5:0]     fr_kind;
  logic           fr_run;
  logic           fr_hash;
  logic           fr_pend;
  logic [5:0]     fr_pend_kind;
  logic           fr_nl;

  logic           is_eol;
  logic           is_digit;
  logic           do_fresh;
  logic [5:0]     run_base;
  logic [5:0]     run_kind;

  function automatic logic [31:0] clamp32(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic mts_pkg::token_t mk_tok(input logic [5:0] k,
                                             input logic [OFFSET_BITS-1:0] s,
                                             input logic [OFFSET_BITS-1:0] e,
                                             input logic [31:0] ln);
    mts_pkg::token_t        t;
    logic [OFFSET_BITS-1:0] d;
    d              = (e >= s) ? e - s : '0;
    t.token_kind   = k;
    t.start_offset = clamp32(s);
    t.token_length = clamp32(d);
    t.line_number  = ln;
    return t;
  endfunction

  assign np       = (&pos_r) ? pos_r : pos_r + 1'b1;
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + 32'd1;
  assign is_eol   = (byte_i == mts_pkg::CH_LF) || (byte_i == mts_pkg::CH_CR);
  assign is_digit = (byte_i >= mts_pkg::CH_ZERO) && (byte_i <= mts_pkg::CH_NINE);

  always_comb begin
    case (run_char_r)
      mts_pkg::CH_STAR:  run_base = mts_pkg::K_STAR;
      mts_pkg::CH_MINUS: run_base = mts_pkg::K_MINUS;
      mts_pkg::CH_UNDER: run_base = mts_pkg::K_UNDER;
      default:           run_base = mts_pkg::K_TICK;
    endcase
    if (run_count_r == 3'd2) begin
      run_kind = run_base + 6'd1;
    end else if (run_count_r == 3'd3) begin
      run_kind = run_base + 6'd2;
    end else begin
      run_kind = run_base;
    end
  end

  // fresh byte decode
  always_comb begin
    fr_mode      = mts_pkg::M_IDLE;
    fr_put       = 1'b0;
    fr_kind      = mts_pkg::K_EOF;
    fr_run       = 1'b0;
    fr_hash      = 1'b0;
    fr_pend      = 1'b0;
    fr_pend_kind = mts_pkg::K_PLUS;
    fr_nl        = 1'b0;
    case (byte_i)
      mts_pkg::CH_HASH: begin
        fr_mode = mts_pkg::M_HEADING;
        fr_hash = 1'b1;
      end
      mts_pkg::CH_LBRACK: begin fr_put = 1'b1; fr_kind = mts_pkg::K_LBRACK; end
      mts_pkg::CH_RBRACK: begin fr_put = 1'b1; fr_kind = mts_pkg::K_RBRACK; end
      mts_pkg::CH_EQ:     begin fr_put = 1'b1; fr_kind = mts_pkg::K_EQ;     end
      mts_pkg::CH_DOT:    begin fr_put = 1'b1; fr_kind = mts_pkg::K_DOT;    end
      mts_pkg::CH_LPAREN: begin fr_put = 1'b1; fr_kind = mts_pkg::K_LPAREN; end
      mts_pkg::CH_RPAREN: begin fr_put = 1'b1; fr_kind = mts_pkg::K_RPAREN; end
      mts_pkg::CH_LT:     begin fr_put = 1'b1; fr_kind = mts_pkg::K_LT;     end
      mts_pkg::CH_BANG:   begin fr_put = 1'b1; fr_kind = mts_pkg::K_BANG;   end
      mts_pkg::CH_TAB:    begin fr_put = 1'b1; fr_kind = mts_pkg::K_TAB;    end
      mts_pkg::CH_PLUS: begin
        fr_mode      = mts_pkg::M_SWALLOW;
        fr_pend      = 1'b1;
        fr_pend_kind = mts_pkg::K_PLUS;
      end
      mts_pkg::CH_GT: begin
        fr_mode      = mts_pkg::M_SWALLOW;
        fr_pend      = 1'b1;
        fr_pend_kind = mts_pkg::K_GT;
      end
      mts_pkg::CH_STAR, mts_pkg::CH_MINUS, mts_pkg::CH_UNDER, mts_pkg::CH_TICK: begin
        fr_mode = mts_pkg::M_RUN;
        fr_run  = 1'b1;
      end
      mts_pkg::CH_LF: begin
        fr_put  = 1'b1;
        fr_kind = mts_pkg::K_NEWLINE;
        fr_nl   = 1'b1;
      end
      default: begin
        fr_mode = is_digit ? mts_pkg::M_NUM : mts_pkg::M_TEXT;
      end
    endcase
  end

  // main step
  always_comb begin
    mode_nxt      = mode_r;
    run_char_nxt  = run_char_r;
    run_count_nxt = run_count_r;
    pend_nxt      = pend_r;
    tstart_nxt    = tstart_r;
    pos_nxt       = pos_r;
    line_nxt      = line_r;
    do_fresh      = 1'b0;
    res_o.a_valid = 1'b0;
    res_o.a_tok   = mk_tok(mts_pkg::K_TEXT, tstart_r, pos_r, line_r);
    res_o.b_valid = 1'b0;
    res_o.b_tok   = mk_tok(mts_pkg::K_EOF, pos_r, pos_r, line_r);

    if (is_end_i) begin
      // flush pending token, then eof at the current position
      case (mode_r)
        mts_pkg::M_SWALLOW: begin
          res_o.a_valid = 1'b1;
          res_o.a_tok   = mk_tok(pend_r, tstart_r, pos_r, line_r);
        end
        mts_pkg::M_RUN: begin
          res_o.a_valid = 1'b1;
          res_o.a_tok   = mk_tok(run_kind, tstart_r, pos_r, line_r);
        end
        mts_pkg::M_HEADING, mts_pkg::M_NUM, mts_pkg::M_TEXT: begin
          res_o.a_valid = 1'b1;
        end
        default: ;
      endcase
      res_o.b_valid = 1'b1;
      mode_nxt      = mts_pkg::M_IDLE;
    end else begin
      pos_nxt = np;
      case (mode_r)
        mts_pkg::M_SWALLOW: begin
          res_o.a_valid = 1'b1;
          res_o.a_tok   = mk_tok(pend_r, tstart_r, np, line_r);
          mode_nxt      = mts_pkg::M_IDLE;
        end
        mts_pkg::M_RUN: begin
          if (byte_i == run_char_r) begin
            if (run_count_r < mts_pkg::RUN_CAP) run_count_nxt = run_count_r + 3'd1;
          end else if (run_count_r == 3'd1 &&
                       (run_char_r == mts_pkg::CH_STAR || run_char_r == mts_pkg::CH_MINUS)) begin
            // lone star or minus swallows this byte
            res_o.a_valid = 1'b1;
            res_o.a_tok   = mk_tok(run_base, tstart_r, np, line_r);
            mode_nxt      = mts_pkg::M_IDLE;
          end else begin
            res_o.a_valid = 1'b1;
            res_o.a_tok   = mk_tok(run_kind, tstart_r, pos_r, line_r);
            do_fresh      = 1'b1;
          end
        end
        mts_pkg::M_HEADING: begin
          if (byte_i == mts_pkg::CH_HASH) begin
            if (run_count_r < mts_pkg::HASH_CAP) run_count_nxt = run_count_r + 3'd1;
          end else if (byte_i == mts_pkg::CH_SPACE) begin
            if (run_count_r >= 3'd1 && run_count_r <= mts_pkg::HEAD_LEVELS) begin
              res_o.a_valid = 1'b1;
              res_o.a_tok   = mk_tok(mts_pkg::K_HEAD_BASE + 6'(run_count_r),
                                     tstart_r, np, line_r);
              mode_nxt      = mts_pkg::M_IDLE;
            end else begin
              mode_nxt = mts_pkg::M_TEXT;
            end
          end else if (is_eol) begin
            res_o.a_valid = 1'b1;
            do_fresh      = 1'b1;
          end else begin
            mode_nxt = mts_pkg::M_TEXT;
          end
        end
        mts_pkg::M_NUM: begin
          if (is_digit) begin
            mode_nxt = mts_pkg::M_NUM;
          end else if (byte_i == mts_pkg::CH_DOT) begin
            mode_nxt = mts_pkg::M_SWALLOW;
            pend_nxt = mts_pkg::K_NUM;
          end else if (is_eol) begin
            res_o.a_valid = 1'b1;
            do_fresh      = 1'b1;
          end else begin
            mode_nxt = mts_pkg::M_TEXT;
          end
        end
        mts_pkg::M_TEXT: begin
          if (is_eol) begin
            res_o.a_valid = 1'b1;
            do_fresh      = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase

      if (do_fresh) begin
        tstart_nxt = pos_r;
        mode_nxt   = fr_mode;
        if (fr_run) begin
          run_char_nxt  = byte_i;
          run_count_nxt = 3'd1;
        end
        if (fr_hash) run_count_nxt = 3'd1;
        if (fr_pend) pend_nxt = fr_pend_kind;
        if (fr_nl) line_nxt = line_inc;
        res_o.b_valid = fr_put;
        res_o.b_tok   = mk_tok(fr_kind, pos_r, np, fr_nl ? line_inc : line_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mts_pkg::M_IDLE;
      run_char_r  <= '0;
      run_count_r <= '0;
      pend_r      <= '0;
      tstart_r    <= '0;
      pos_r       <= '0;
      line_r      <= 32'd1;
    end else if (fire_i) begin
      mode_r      <= mode_nxt;
      run_char_r  <= run_char_nxt;
      run_count_r <= run_count_nxt;
      pend_r      <= pend_nxt;
      tstart_r    <= tstart_nxt;
      pos_r       <= pos_nxt;
      line_r      <= line_nxt;
    end
  end

endmodule

// File: rtl/core/mts_outbuf.sv
// ----------------------------------------------------------------------------
// mts_outbuf
// two-entry result register that feeds the output stream one word at a time
// ----------------------------------------------------------------------------
module mts_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  mts_pkg::res_pair_t  res_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mts_pkg::token_t     out_tok_o,
  output logic                out_last_o
);

  logic [1:0]       cnt_r, cnt_nxt;
  mts_pkg::token_t  tok0_r, tok0_nxt;
  mts_pkg::token_t  tok1_r, tok1_nxt;
  logic             last0_r, last0_nxt;
  logic             pop;

  assign out_valid_o = (cnt_r != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // loading only when the buffer is empty or drains this cycle
  assign can_load_o  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready_i);
  assign out_tok_o   = tok0_r;
  assign out_last_o  = last0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    tok0_nxt  = tok0_r;
    tok1_nxt  = tok1_r;
    last0_nxt = last0_r;
    if (load_i) begin
      // compact: primary first, second token behind it
      tok0_nxt  = res_i.a_valid ? res_i.a_tok : res_i.b_tok;
      tok1_nxt  = res_i.b_tok;
      last0_nxt = !(res_i.a_valid && res_i.b_valid);
      cnt_nxt   = 2'(res_i.a_valid) + 2'(res_i.b_valid);
    end else if (pop) begin
      tok0_nxt  = tok1_r;
      last0_nxt = 1'b1;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    tok0_r  <= tok0_nxt;
    tok1_r  <= tok1_nxt;
    last0_r <= last0_nxt;
  end

endmodule

// File: rtl/core/markup_token_scanner_top.sv
// ----------------------------------------------------------------------------
// markup_token_scanner_top
// streaming tokenizer for markdown-like text, one byte per input word
// ----------------------------------------------------------------------------
// usage:
//   input stream: in_tdata carries one byte, in_tuser flags end of input
//   (the byte is then ignored). output stream: one token per word, with
//   kind, start offset, length and line number in out_tdata; out_tlast
//   marks the final token caused by one input word.
// each input word gives zero, one or two tokens. an end word flushes any
//   pending token and then gives an eof token of length zero.
// latency: a word's first token is registered at the edge that accepts the word
//   and shows on the output in the following cycle; a second token follows it.
// throughput: one input word per cycle while each word makes at most one
//   token and the receiver keeps up; a word that makes two tokens holds the
//   input back until its first token has been taken, since the output
//   register drains one word a cycle.
// stall: when out_tready is low the result register holds its words and
//   in_tready drops once the register cannot take a new word's tokens.
// reset: rst_n (synchronous, active low) empties the result register,
//   returns the scanner to idle with offset zero and line count one.
// ----------------------------------------------------------------------------
module markup_token_scanner_top #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] byte_req
  input  logic [0:0]                      in_tuser,   // [0] kind (1 = end of input)
  // token stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [5:0] token_kind, [37:6] start_offset, [69:38] token_length,
  // [101:70] line_number, [103:102] zero
  output logic [mts_pkg::TDATA_BITS-1:0]  out_tdata,
  output logic                            out_tlast
);

  logic                in_fire;
  logic                buf_can_load;
  mts_pkg::res_pair_t  step_res;
  mts_pkg::token_t     out_tok;

  // input word is taken whenever the result register can absorb its tokens
  assign in_tready = buf_can_load;
  assign in_fire   = in_tvalid && in_tready;

  // state update and token decode
  mts_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (in_fire),
    .is_end_i (in_tuser[0]),
    .byte_i   (in_tdata),
    .res_o    (step_res)
  );

  // result register, drained one token per output word
  mts_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (in_fire),
    .res_i       (step_res),
    .can_load_o  (buf_can_load),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_tok_o   (out_tok),
    .out_last_o  (out_tlast)
  );

  assign out_tdata = {{(mts_pkg::TDATA_BITS - mts_pkg::TOKEN_BITS){1'b0}}, out_tok};

endmodule
